[sv/htd_pkg.sv]
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants of the Huffman tree decoder
// Field widths, request codes and the packed layout of one tree node.
// ----------------------------------------------------------------------------
package htd_pkg;

	localparam int IDX_W       = 9;
	localparam int SYM_W       = 8;
	localparam int BYTE_W      = 8;
	localparam int NBITS_W     = 4;
	localparam int MAX_NODES_D = 512;
	localparam int S_TDATA_W   = 48;

	// request kinds carried in tuser
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] symbol;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
	} node_t;

endpackage

[sv/huffman_tree_decoder.sv]
// ----------------------------------------------------------------------------
// huffman_tree_decoder: bit-serial Huffman decoder over a node table
// Walks a code tree one code bit per cycle unless stalled; one beat per symbol.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): tuser selects the request. A load beat writes one
//   node into the table and returns the walk to the root (node 0). A decode
//   beat brings one code byte whose leading valid_bits bits are decoded, most
//   significant bit first; the walk position carries over to the next byte.
//   Master channel (m_*): one beat per decoded symbol, tlast on the final
//   symbol of a code byte. A byte that completes no symbol gives no beat.
// Timing:
//   A code byte holds s_tready low while its valid_bits bits are walked
//   (counts above eight act as eight) and through a closing flush step, plus
//   another when its last bit ends a symbol while an earlier one is still
//   held; each bit costs one dependent read of the node table (registered
//   read data, child select, next read address). A symbol beat waits until
//   the next symbol of the byte is found; the final one leaves in a flush step.
// Reset:
//   arst_n clears the byte in flight, the pending read and the output valid.
//   Walk position and node table are not cleared; nodes are undefined until loaded.
// Stall:
//   While a symbol waits on m_tready the bit walk holds, read data included.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
	parameter int MAX_NODES = htd_pkg::MAX_NODES_D
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// low to high: node_index[8:0], node_is_leaf[9], node_symbol[17:10],
	// node_left[26:18], node_right[35:27], code_byte[43:36], valid_bits[47:44]
	input  logic [htd_pkg::S_TDATA_W-1:0] s_tdata,
	// low to high: req_type[0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// low to high: symbol[7:0]
	output logic [htd_pkg::SYM_W-1:0]     m_tdata,
	output logic                           m_tlast
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int IW = htd_pkg::IDX_W;

	// unpacked request fields
	logic [IW-1:0]                   node_index;
	htd_pkg::node_t                  new_node;
	logic [htd_pkg::BYTE_W-1:0]      code_byte;
	logic [htd_pkg::NBITS_W-1:0]     valid_bits;

	assign node_index      = s_tdata[8:0];
	assign new_node.leaf   = s_tdata[9];
	assign new_node.symbol = s_tdata[17:10];
	assign new_node.left   = s_tdata[26:18];
	assign new_node.right  = s_tdata[35:27];
	assign code_byte       = s_tdata[43:36];
	assign valid_bits      = s_tdata[47:44];

	// node table and its registered read port
	htd_pkg::node_t mem [MAX_NODES];
	htd_pkg::node_t rdata_s1;
	logic           rd_pend_s1;
	logic           rd_oor_s1;

	// walk state
	htd_pkg::node_t              root_q;   // copy of node 0
	htd_pkg::node_t              cur_q;    // node at the walk position
	logic [htd_pkg::BYTE_W-1:0]  sh_q;     // code bits, next bit at the top
	logic [htd_pkg::NBITS_W-1:0] cnt_q;    // code bits still to walk
	logic                        busy_q;

	// one decoded symbol held back until we know whether it ends the byte
	logic [htd_pkg::SYM_W-1:0]   hold_sym_q;
	logic                        hold_v_q;

	// output register
	logic                        m_tvalid_q;
	logic [htd_pkg::SYM_W-1:0]   out_sym_q;
	logic                        out_last_q;

	// step logic
	logic                        s_acc;
	logic                        load_acc;
	logic                        dec_acc;
	logic                        wr_en;
	logic [AW-1:0]               waddr;
	logic                        adv;
	logic                        step;
	htd_pkg::node_t              ne;
	htd_pkg::node_t              cur_eff;
	logic                        e_new;
	logic [IW-1:0]               child;
	logic                        issue;
	logic                        child_oor;
	logic [AW-1:0]               raddr;
	logic                        push;
	logic [htd_pkg::SYM_W-1:0]   push_sym;
	logic                        push_last;
	logic [AW+IW-1:0]            waddr_ext;
	logic [AW+IW-1:0]            raddr_ext;

	assign s_tready = !busy_q;
	assign s_acc    = s_tvalid && s_tready;
	assign load_acc = s_acc && (s_tuser == htd_pkg::REQ_LOAD);
	assign dec_acc  = s_acc && (s_tuser == htd_pkg::REQ_DECODE);

	// loads beyond the table are dropped
	assign wr_en     = load_acc && (32'(node_index) < MAX_NODES);
	assign waddr_ext = {{AW{1'b0}}, node_index};
	assign waddr     = waddr_ext[AW-1:0];

	// advance only when the output register can take a beat
	assign adv  = !m_tvalid_q || m_tready;
	assign step = busy_q && adv;

	always_comb begin
		// a child beyond the table reads as an all-zero inner node
		ne      = rd_oor_s1 ? '0 : rdata_s1;
		e_new   = rd_pend_s1 && ne.leaf;
		if (!rd_pend_s1) begin
			cur_eff = cur_q;
		end else if (ne.leaf) begin
			cur_eff = root_q;
		end else begin
			cur_eff = ne;
		end
		child     = sh_q[htd_pkg::BYTE_W-1] ? cur_eff.right : cur_eff.left;
		child_oor = !(32'(child) < MAX_NODES);
		issue     = step && (cnt_q != '0) && !cur_eff.leaf;
	end

	assign raddr_ext = {{AW{1'b0}}, child};
	assign raddr     = raddr_ext[AW-1:0];

	// result selection: a fresh symbol pushes the held one out (not last);
	// at the end of the byte the held symbol leaves with last set
	always_comb begin
		push      = 1'b0;
		push_sym  = hold_sym_q;
		push_last = 1'b0;
		if (step) begin
			if (cnt_q != '0) begin
				push = e_new && hold_v_q;
			end else if (hold_v_q) begin
				push      = 1'b1;
				push_last = !e_new;
			end else if (e_new) begin
				push      = 1'b1;
				push_sym  = ne.symbol;
				push_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= new_node;
		end
		if (issue) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			// any load returns the walk to the root
			if (node_index == '0) begin
				root_q <= new_node;
				cur_q  <= new_node;
			end else begin
				cur_q  <= root_q;
			end
		end else if (step) begin
			cur_q <= cur_eff.leaf ? root_q : cur_eff;
		end
		if (dec_acc) begin
			sh_q <= code_byte;
		end else if (step) begin
			sh_q <= {sh_q[htd_pkg::BYTE_W-2:0], 1'b0};
		end
		if (step && e_new) begin
			hold_sym_q <= ne.symbol;
		end
		if (push) begin
			out_sym_q  <= push_sym;
			out_last_q <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cnt_q      <= '0;
			rd_pend_s1 <= 1'b0;
			rd_oor_s1  <= 1'b0;
			hold_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (dec_acc) begin
				busy_q <= 1'b1;
				cnt_q  <= (valid_bits > 4'd8) ? 4'd8 : valid_bits;
			end else if (step) begin
				rd_pend_s1 <= issue;
				if (issue) begin
					rd_oor_s1 <= child_oor;
				end
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 4'd1;
					if (e_new) begin
						hold_v_q <= 1'b1;
					end
				end else if (hold_v_q && e_new) begin
					// keep the newest symbol for another flush step
					hold_v_q <= 1'b1;
				end else begin
					hold_v_q <= 1'b0;
					busy_q   <= 1'b0;
				end
			end
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_last_q;

	// a read is only outstanding inside a byte
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> busy_q)
		else $error("table read pending while idle");

	// no symbol may be held across bytes
	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !hold_v_q)
		else $error("held symbol left behind at end of byte");

	// the bit count runs out before the decoder goes idle
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0))
		else $error("code bits left while idle");

	// never overwrite a beat that the receiver has not taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !push)
		else $error("output beat overwritten during stall");

endmodule

[tb/sv/huffman_tree_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_test: self-checking bench of the Huffman tree decoder
// Loads code trees node by node, streams code bytes through them and checks
// every symbol beat against a tree walk kept in the bench, under random
// backpressure and source gaps on both channels.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_test;

	// one slave beat; the bench packs its fields into s_tdata/s_tuser on sending
	typedef struct packed {
		logic                        kind;
		logic [htd_pkg::IDX_W-1:0]   slot;
		logic                        leaf;
		logic [htd_pkg::SYM_W-1:0]   symbol;
		logic [htd_pkg::IDX_W-1:0]   left;
		logic [htd_pkg::IDX_W-1:0]   right;
		logic [htd_pkg::BYTE_W-1:0]  code;
		logic [htd_pkg::NBITS_W-1:0] nbits;
	} tree_req_t;

	// one master beat
	typedef struct packed {
		logic [htd_pkg::SYM_W-1:0] symbol;
		logic                      last;
	} sym_beat_t;

	localparam int RAND_REQS  = 440;
	localparam int DRAIN_CYC  = 40;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [htd_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
	logic                            s_tuser  = htd_pkg::REQ_LOAD;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [htd_pkg::SYM_W-1:0]       m_tdata;
	logic                            m_tlast;

	tree_req_t  code_reqs[$];       // beats still to be sent
	tree_req_t  tree_loads[$];      // node loads of the tree in use
	tree_req_t  cur_req;            // beat on the slave bus right now
	sym_beat_t  expected_syms[$];   // symbols still owed by the decoder
	sym_beat_t  want;
	htd_pkg::node_t node_mem [0:htd_pkg::MAX_NODES_D-1];
	logic [htd_pkg::IDX_W-1:0] walk_pos = '0;
	bit         in_tree [0:htd_pkg::MAX_NODES_D-1];
	bit         req_taken = 1'b0;
	int         n_sent    = 0;
	int         n_total   = 1;
	int         n_fail    = 0;

	huffman_tree_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Idle share in percent for this part of the run: the sender gaps lightly
	// while the receiver stalls hard, then the other way round, then no idling.
	function automatic int idle_pct(input bit receiver);
		int third;
		third = n_sent * 3 / n_total;
		if (third == 0)
			return receiver ? 49 : 7;
		if (third == 1)
			return receiver ? 7 : 49;
		return 0;
	endfunction

	function automatic tree_req_t random_req();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(tree_req_t)-1:0];
	endfunction

	task automatic push_load(input logic [htd_pkg::IDX_W-1:0] slot, input logic leaf,
			input logic [htd_pkg::SYM_W-1:0] symbol,
			input logic [htd_pkg::IDX_W-1:0] left,
			input logic [htd_pkg::IDX_W-1:0] right);
		tree_req_t r;
		r        = random_req();
		r.kind   = htd_pkg::REQ_LOAD;
		r.slot   = slot;
		r.leaf   = leaf;
		r.symbol = symbol;
		r.left   = left;
		r.right  = right;
		code_reqs.insert(code_reqs.size(), r);
	endtask

	task automatic push_decode(input logic [htd_pkg::BYTE_W-1:0] code,
			input logic [htd_pkg::NBITS_W-1:0] nbits);
		tree_req_t r;
		r       = random_req();
		r.kind  = htd_pkg::REQ_DECODE;
		r.code  = code;
		r.nbits = nbits;
		code_reqs.insert(code_reqs.size(), r);
	endtask

	// Grow a random full binary tree with the given number of leaves, root in
	// slot 0 and every other node in a distinct random slot, then queue its
	// node loads in random order. Every child points at a node of this tree,
	// so a walk never lands on a slot that was never loaded.
	task automatic build_tree(input int n_leaves);
		logic [htd_pkg::IDX_W-1:0] slot[$];
		bit               is_leaf[$];
		int               lc[$], rc[$];
		int               leaves, j, s;
		tree_req_t        ld;
		for (s = 0; s < htd_pkg::MAX_NODES_D; s++)
			in_tree[s] = 1'b0;
		slot = {9'd0};
		is_leaf = {1'b1};
		lc = {0};
		rc = {0};
		in_tree[0] = 1'b1;
		leaves = 1;
		while (leaves < n_leaves) begin
			do j = $urandom_range(0, slot.size() - 1); while (!is_leaf[j]);
			is_leaf[j] = 1'b0;
			lc[j] = slot.size();
			rc[j] = slot.size() + 1;
			repeat (2) begin
				do s = $urandom_range(1, htd_pkg::MAX_NODES_D - 1); while (in_tree[s]);
				in_tree[s] = 1'b1;
				slot.insert(slot.size(), 9'(s));
				is_leaf.insert(is_leaf.size(), 1'b1);
				lc.insert(lc.size(), 0);
				rc.insert(rc.size(), 0);
			end
			leaves++;
		end
		tree_loads.delete();
		for (j = 0; j < slot.size(); j++) begin
			ld      = random_req();
			ld.kind = htd_pkg::REQ_LOAD;
			ld.slot = slot[j];
			ld.leaf = is_leaf[j];
			if (!is_leaf[j]) begin
				ld.left  = slot[lc[j]];
				ld.right = slot[rc[j]];
			end
			tree_loads.insert(tree_loads.size(), ld);
		end
		// now and then bend one edge back into the tree: loops, shared subtrees
		if (n_leaves > 1 && chance(15)) begin
			do j = $urandom_range(0, slot.size() - 1); while (is_leaf[j]);
			ld = tree_loads[j];
			if ($urandom_range(0, 1))
				ld.left = slot[$urandom_range(0, slot.size() - 1)];
			else
				ld.right = slot[$urandom_range(0, slot.size() - 1)];
			tree_loads[j] = ld;
		end
		for (j = tree_loads.size() - 1; j > 0; j--) begin
			s = $urandom_range(0, j);
			ld = tree_loads[j];
			tree_loads[j] = tree_loads[s];
			tree_loads[s] = ld;
		end
		foreach (tree_loads[j])
			code_reqs.insert(code_reqs.size(), tree_loads[j]);
	endtask

	// Walk the tree for one accepted beat and queue the symbols it completes.
	task automatic predict_symbols(input tree_req_t r);
		logic [htd_pkg::SYM_W-1:0] found[$];
		htd_pkg::node_t            here, child;
		logic [htd_pkg::IDX_W-1:0] next;
		int                        nbits, i;
		if (r.kind == htd_pkg::REQ_LOAD) begin
			node_mem[r.slot] = {r.leaf, r.symbol, r.left, r.right};
			walk_pos = '0;
		end else begin
			nbits = (r.nbits > htd_pkg::BYTE_W) ? htd_pkg::BYTE_W : r.nbits;
			for (i = 0; i < nbits; i++) begin
				here = node_mem[walk_pos];
				if (here.leaf) begin
					// lone-leaf root: swallow the bit, restart at the root
					walk_pos = '0;
				end else begin
					next  = r.code[htd_pkg::BYTE_W-1-i] ? here.right : here.left;
					child = node_mem[next];
					if (child.leaf) begin
						found.insert(found.size(), child.symbol);
						walk_pos = '0;
					end else begin
						walk_pos = next;
					end
				end
			end
			foreach (found[i])
				expected_syms.insert(expected_syms.size(),
					sym_beat_t'{symbol: found[i], last: (i == found.size() - 1)});
		end
	endtask

	// Slave side: note the accepted beat at the rising edge ...
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predict_symbols(cur_req);
			n_sent++;
			req_taken = 1'b1;
		end
	end

	// ... and present the next one at the falling edge. Hold a beat that is
	// still waiting; once taken, advance or idle.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || req_taken) begin
				if (code_reqs.size() != 0 && !chance(idle_pct(1'b0))) begin
					cur_req = code_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_req.kind;
					s_tdata  <= {cur_req.nbits, cur_req.code, cur_req.right, cur_req.left,
						cur_req.symbol, cur_req.leaf, cur_req.slot};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			req_taken = 1'b0;
		end
	end

	// Master side: stall at random, check each symbol beat against the oldest
	// symbol owed.
	always @(negedge clk) begin
		m_tready <= arst_n && !chance(idle_pct(1'b1));
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_syms.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected symbol beat: symbol=%02h last=%0b",
						m_tdata, m_tlast);
			end else begin
				want = expected_syms.pop_front();
				if (m_tdata !== want.symbol || m_tlast !== want.last) begin
					n_fail++;
					if (n_fail <= 10)
						$display({"symbol beat mismatch: expected symbol=%02h last=%0b,",
							" got symbol=%02h last=%0b"},
							want.symbol, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	initial begin
		int n_directed, n_leaves, n_bytes, k, s;

		// Directed: a lone-leaf root swallows every bit.
		push_load(9'd0, 1'b1, 8'hFF, 9'd511, 9'd511);
		push_decode(8'hFF, 4'd8);
		// Codes 0 -> 00, 10 -> FF, 11 -> 80, using the outer slots.
		push_load(9'd0,   1'b0, 8'h5A, 9'd511, 9'd256);
		push_load(9'd511, 1'b1, 8'h00, 9'd0,   9'd0);
		push_load(9'd256, 1'b0, 8'hC3, 9'd1,   9'd2);
		push_load(9'd1,   1'b1, 8'hFF, 9'd511, 9'd511);
		push_load(9'd2,   1'b1, 8'h80, 9'd0,   9'd511);
		push_decode(8'h00, 4'd8);    // eight symbols from one byte
		push_decode(8'hFF, 4'd8);
		push_decode(8'h80, 4'd1);    // stops mid-code, no beat
		push_decode(8'h00, 4'd1);    // finishes that code in the next byte
		push_decode(8'hFF, 4'd0);    // nothing to decode
		push_decode(8'h55, 4'd15);   // oversized bit count acts as eight
		push_decode(8'h40, 4'd9);
		push_decode(8'hA0, 4'd3);    // leaves the walk inside the tree
		push_load(9'd2, 1'b1, 8'h80, 9'd0, 9'd511);  // load drops the walk to the root
		push_decode(8'h7F, 4'd2);
		push_decode(8'h80, 4'd1);
		// right child of the inner node points back at the root
		push_load(9'd256, 1'b0, 8'h11, 9'd1, 9'd0);
		push_decode(8'hC0, 4'd4);
		n_directed = code_reqs.size();

		// Random: mostly loaded trees fed with random code bytes; some node
		// reloads in mid-stream, some loads into slots outside the tree.
		while (code_reqs.size() - n_directed < RAND_REQS) begin
			if (chance(5))
				n_leaves = 1;
			else if (chance(10))
				n_leaves = $urandom_range(9, 40);
			else
				n_leaves = $urandom_range(2, 8);
			build_tree(n_leaves);
			n_bytes = $urandom_range(4, 24);
			for (k = 0; k < n_bytes; k++) begin
				if (chance(8)) begin
					code_reqs.insert(code_reqs.size(),
						tree_loads[$urandom_range(0, tree_loads.size() - 1)]);
				end else if (chance(5)) begin
					do s = $urandom_range(0, htd_pkg::MAX_NODES_D - 1); while (in_tree[s]);
					push_load(9'(s), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
				end
				if (chance(85))
					push_decode(8'($urandom_range(0, 255)), 4'($urandom_range(1, 8)));
				else
					push_decode(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
			end
		end
		n_total = code_reqs.size();

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// drain: every beat sent, every symbol back, then watch for strays
		while (n_sent < n_total || expected_syms.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);

		if (n_fail == 0 && expected_syms.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
